// ----- sv/pdu_pkg.sv -----
package pdu_pkg;

  localparam int unsigned QBITS = 32;
  localparam int unsigned AD_W  = 48;
  localparam int unsigned DEN_W = 49;

  localparam logic signed [31:0] DEP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DEP_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
    logic        eof;
  } side_t;

endpackage

// ----- sv/pdu_gen.sv -----
module pdu_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [1:0]          lg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_coef_nx,
  input  logic signed [31:0]  in_coef_ny,
  input  logic signed [31:0]  in_coef_nz,
  input  logic signed [31:0]  in_coef_dist,
  input  logic [8:0]          in_cell_row,
  input  logic [8:0]          in_cell_col,
  input  logic                in_last_cell,
  output logic                pix_valid,
  output logic signed [31:0]  pix_nx,
  output logic signed [31:0]  pix_ny,
  output logic signed [31:0]  pix_nz,
  output logic signed [31:0]  pix_dist,
  output logic signed [15:0]  pix_uq,
  output logic signed [15:0]  pix_vq,
  output pdu_pkg::side_t      pix_side
);
  import pdu_pkg::*;

  logic               busy_r;
  logic [2:0]         s_r, t_r;
  logic signed [31:0] nx_r, ny_r, nz_r, dist_r;
  logic [8:0]         row_r, col_r;
  logic               lastc_r;
  logic               v_r;
  logic signed [31:0] onx_r, ony_r, onz_r, odist_r;
  logic signed [15:0] uq_r, vq_r;
  side_t              side_r;

  logic [2:0]         lim;
  logic               last_pix;
  logic [4:0]         ratio;
  logic signed [4:0]  off_u, off_v;
  logic [3:0]         shamt;
  logic signed [15:0] uq_nxt, vq_nxt;
  side_t              side_nxt;
  logic               acc;

  assign lim      = 3'((4'd1 << lg) - 4'd1);
  assign last_pix = (t_r == lim) && (s_r == lim);
  assign ratio    = 5'(5'd1 << lg);
  assign off_u    = $signed({1'b0, t_r, 1'b1}) - $signed(ratio);
  assign off_v    = $signed({1'b0, s_r, 1'b1}) - $signed(ratio);
  assign shamt    = 4'd15 - {2'b00, lg};
  assign uq_nxt   = $signed({{11{off_u[4]}}, off_u}) <<< shamt;
  assign vq_nxt   = $signed({{11{off_v[4]}}, off_v}) <<< shamt;

  always_comb begin
    side_nxt.row  = 12'(({3'b000, row_r} << lg) + {9'd0, s_r});
    side_nxt.col  = 12'(({3'b000, col_r} << lg) + {9'd0, t_r});
    side_nxt.last = last_pix;
    side_nxt.eof  = last_pix && lastc_r;
  end

  assign in_ready = !busy_r || (adv && last_pix);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      s_r    <= '0;
      t_r    <= '0;
      v_r    <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= busy_r;
      end
      if (acc) begin
        busy_r <= 1'b1;
        s_r    <= '0;
        t_r    <= '0;
      end else if (adv && busy_r) begin
        if (last_pix) begin
          busy_r <= 1'b0;
        end else if (t_r == lim) begin
          t_r <= '0;
          s_r <= s_r + 3'd1;
        end else begin
          t_r <= t_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      nx_r    <= in_coef_nx;
      ny_r    <= in_coef_ny;
      nz_r    <= in_coef_nz;
      dist_r  <= in_coef_dist;
      row_r   <= in_cell_row;
      col_r   <= in_cell_col;
      lastc_r <= in_last_cell;
    end
    if (adv && busy_r) begin
      onx_r   <= nx_r;
      ony_r   <= ny_r;
      onz_r   <= nz_r;
      odist_r <= dist_r;
      uq_r    <= uq_nxt;
      vq_r    <= vq_nxt;
      side_r  <= side_nxt;
    end
  end

  assign pix_valid = v_r;
  assign pix_nx    = onx_r;
  assign pix_ny    = ony_r;
  assign pix_nz    = onz_r;
  assign pix_dist  = odist_r;
  assign pix_uq    = uq_r;
  assign pix_vq    = vq_r;
  assign pix_side  = side_r;

endmodule

// ----- sv/pdu_den.sv -----
module pdu_den (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       pix_valid,
  input  logic signed [31:0]         pix_nx,
  input  logic signed [31:0]         pix_ny,
  input  logic signed [31:0]         pix_nz,
  input  logic signed [31:0]         pix_dist,
  input  logic signed [15:0]         pix_uq,
  input  logic signed [15:0]         pix_vq,
  input  pdu_pkg::side_t             pix_side,
  output logic                       d_valid,
  output logic [31:0]                d_an,
  output logic [pdu_pkg::AD_W-1:0]   d_ad,
  output logic                       d_neg,
  output logic                       d_zero,
  output logic                       d_sat,
  output pdu_pkg::side_t             d_side
);
  import pdu_pkg::*;

  logic                    v1_r, v2_r;
  logic signed [47:0]      pu_r, pv_r;
  logic signed [31:0]      nz_r, dist_r;
  side_t                   side1_r, side2_r;
  logic [31:0]             an_r;
  logic [AD_W-1:0]         ad_r;
  logic                    neg_r, zero_r, sat_r;

  logic signed [DEN_W-1:0] den;
  logic [DEN_W-1:0]        den_abs;
  logic [31:0]             an_nxt;

  assign den = DEN_W'(pu_r) + DEN_W'(pv_r) + DEN_W'($signed({nz_r, 16'h0000}));
  assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign an_nxt  = dist_r[31] ? 32'(-dist_r) : 32'(dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pix_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pu_r    <= pix_nx * pix_uq;
      pv_r    <= pix_ny * pix_vq;
      nz_r    <= pix_nz;
      dist_r  <= pix_dist;
      side1_r <= pix_side;
      an_r    <= an_nxt;
      ad_r    <= den_abs[AD_W-1:0];
      neg_r   <= dist_r[31] != den[DEN_W-1];
      zero_r  <= den == '0;
      sat_r   <= {16'h0000, an_nxt} >= den_abs[AD_W-1:0];
      side2_r <= side1_r;
    end
  end

  assign d_valid = v2_r;
  assign d_an    = an_r;
  assign d_ad    = ad_r;
  assign d_neg   = neg_r;
  assign d_zero  = zero_r;
  assign d_sat   = sat_r;
  assign d_side  = side2_r;

endmodule

// ----- sv/pdu_div.sv -----
module pdu_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       d_valid,
  input  logic [31:0]                d_an,
  input  logic [pdu_pkg::AD_W-1:0]   d_ad,
  input  logic                       d_neg,
  input  logic                       d_zero,
  input  logic                       d_sat,
  input  pdu_pkg::side_t             d_side,
  output logic                       q_valid,
  output logic [pdu_pkg::QBITS-1:0]  q_quot,
  output logic                       q_neg,
  output logic                       q_zero,
  output logic                       q_sat,
  output pdu_pkg::side_t             q_side
);
  import pdu_pkg::*;

  logic             v_r    [QBITS];
  logic [AD_W-1:0]  rem_r  [QBITS];
  logic [AD_W-1:0]  ad_r   [QBITS];
  logic [QBITS-1:0] q_r    [QBITS];
  logic             neg_r  [QBITS];
  logic             zero_r [QBITS];
  logic             sat_r  [QBITS];
  side_t            side_r [QBITS];

  logic             sv     [QBITS];
  logic [AD_W-1:0]  srem   [QBITS];
  logic [AD_W-1:0]  sad    [QBITS];
  logic [QBITS-1:0] sq     [QBITS];
  logic             sneg   [QBITS];
  logic             szero  [QBITS];
  logic             ssat   [QBITS];
  side_t            sside  [QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    logic [AD_W:0] shifted;
    logic          ge;

    if (i == 0) begin : g_first
      assign sv[i]    = d_valid;
      assign srem[i]  = (d_sat || d_zero) ? '0 : {{(AD_W-32){1'b0}}, d_an};
      assign sad[i]   = d_ad;
      assign sq[i]    = '0;
      assign sneg[i]  = d_neg;
      assign szero[i] = d_zero;
      assign ssat[i]  = d_sat;
      assign sside[i] = d_side;
    end else begin : g_next
      assign sv[i]    = v_r[i-1];
      assign srem[i]  = rem_r[i-1];
      assign sad[i]   = ad_r[i-1];
      assign sq[i]    = q_r[i-1];
      assign sneg[i]  = neg_r[i-1];
      assign szero[i] = zero_r[i-1];
      assign ssat[i]  = sat_r[i-1];
      assign sside[i] = side_r[i-1];
    end

    assign shifted = {srem[i], 1'b0};
    assign ge      = shifted >= {1'b0, sad[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= ge ? AD_W'(shifted - {1'b0, sad[i]}) : AD_W'(shifted);
        ad_r[i]   <= sad[i];
        q_r[i]    <= {sq[i][QBITS-2:0], ge};
        neg_r[i]  <= sneg[i];
        zero_r[i] <= szero[i];
        sat_r[i]  <= ssat[i];
        side_r[i] <= sside[i];
      end
    end
  end

  assign q_valid = v_r[QBITS-1];
  assign q_quot  = q_r[QBITS-1];
  assign q_neg   = neg_r[QBITS-1];
  assign q_zero  = zero_r[QBITS-1];
  assign q_sat   = sat_r[QBITS-1];
  assign q_side  = side_r[QBITS-1];

endmodule

// ----- sv/plane_to_depth_upsampler_unit.sv -----
// An item passes the sequencer's input and pixel registers, the denominator and divider stages and
// the output register. Throughput: one result, and one pixel from the sequencer, per cycle unless
// the output stalls. An item yields 1, 4, 16 or 64 results; the next is accepted as its last pixel
// issues. The 32-stage restoring divider produces one quotient bit per stage and shares the stall.
// Reset (rst_n, synchronous, active low) clears all valid bits, the sequencer and the ratio.
module plane_to_depth_upsampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_upratio_log2,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coef_nx,
  input  logic signed [31:0] in_coef_ny,
  input  logic signed [31:0] in_coef_nz,
  input  logic signed [31:0] in_coef_dist,
  input  logic [8:0]         in_cell_row,
  input  logic [8:0]         in_cell_col,
  input  logic               in_last_cell,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_depth_value,
  output logic [11:0]        out_fine_row,
  output logic [11:0]        out_fine_col,
  output logic               out_last_of_cell,
  output logic               out_end_of_frame,
  output logic               out_zero_denominator
);
  import pdu_pkg::*;

  logic               lg_r;
  logic [1:0]         lg2_r;
  logic               adv;

  logic               pix_valid;
  logic signed [31:0] pix_nx, pix_ny, pix_nz, pix_dist;
  logic signed [15:0] pix_uq, pix_vq;
  side_t              pix_side;

  logic               d_valid, d_neg, d_zero, d_sat;
  logic [31:0]        d_an;
  logic [AD_W-1:0]    d_ad;
  side_t              d_side;

  logic               q_valid, q_neg, q_zero, q_sat;
  logic [QBITS-1:0]   q_quot;
  side_t              q_side;

  logic               ov_r;
  logic signed [31:0] dep_r;
  logic signed [31:0] dep_nxt;
  side_t              side_r;
  logic               zf_r;

  assign adv = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg2_r <= '0;
      lg_r  <= 1'b0;
    end else begin
      lg_r <= cfg_we;
      if (cfg_we) begin
        lg2_r <= cfg_upratio_log2;
      end
    end
  end

  pdu_gen u_gen (
    .clk, .rst_n, .adv, .lg(lg2_r),
    .in_valid, .in_ready, .in_coef_nx, .in_coef_ny, .in_coef_nz, .in_coef_dist,
    .in_cell_row, .in_cell_col, .in_last_cell,
    .pix_valid, .pix_nx, .pix_ny, .pix_nz, .pix_dist, .pix_uq, .pix_vq, .pix_side
  );

  pdu_den u_den (
    .clk, .rst_n, .adv,
    .pix_valid, .pix_nx, .pix_ny, .pix_nz, .pix_dist, .pix_uq, .pix_vq, .pix_side,
    .d_valid, .d_an, .d_ad, .d_neg, .d_zero, .d_sat, .d_side
  );

  pdu_div u_div (
    .clk, .rst_n, .adv,
    .d_valid, .d_an, .d_ad, .d_neg, .d_zero, .d_sat, .d_side,
    .q_valid, .q_quot, .q_neg, .q_zero, .q_sat, .q_side
  );

  always_comb begin
    priority if (q_zero) begin
      dep_nxt = DEP_MAX;
    end else if (q_neg) begin
      dep_nxt = (q_sat || q_quot > 32'h8000_0000) ? DEP_MIN : 32'(-q_quot);
    end else begin
      dep_nxt = (q_sat || q_quot[31]) ? DEP_MAX : 32'(q_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dep_r  <= dep_nxt;
      side_r <= q_side;
      zf_r   <= q_zero;
    end
  end

  assign out_valid            = ov_r;
  assign out_depth_value      = dep_r;
  assign out_fine_row         = side_r.row;
  assign out_fine_col         = side_r.col;
  assign out_last_of_cell     = side_r.last;
  assign out_end_of_frame     = side_r.eof;
  assign out_zero_denominator = zf_r;

  a_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |-> out_depth_value == DEP_MAX)
    else $error("zero denominator without maximum depth");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_cell)
    else $error("end of frame away from the last pixel of a cell");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth_value))
    else $error("result lost during a stall");

  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    lg_r |-> lg2_r == $past(cfg_upratio_log2))
    else $error("ratio register not written");

endmodule
